>>> sv/tdre_pkg.sv
`default_nettype none

package tdre_pkg;

   // display geometry
   localparam int ROWS = 4;

   // character constants
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] BLINK_MARK = 8'h80;
   localparam logic [7:0] CHAR_MASK  = 8'h7f;

   // request modes
   localparam logic [2:0] MODE_REFRESH      = 3'd0;
   localparam logic [2:0] MODE_PUT_AT       = 3'd1;
   localparam logic [2:0] MODE_PUT_NEXT     = 3'd2;
   localparam logic [2:0] MODE_MARK_BLINK   = 3'd3;
   localparam logic [2:0] MODE_CLEAR        = 3'd4;
   localparam logic [2:0] MODE_TOGGLE_PHASE = 3'd5;
   localparam logic [2:0] MODE_SET_PHASE    = 3'd6;

   // result kinds
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_CURSOR = 2'd1;
   localparam logic [1:0] KIND_CHAR   = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   // refresh phase: 0..3 cursor to that row next, data otherwise
   localparam logic [2:0] PHASE_DATA = 3'd4;

   // configuration registers, word index
   localparam logic CSR_IDX_COLUMNS = 1'b0;
   localparam logic CSR_IDX_BLINK   = 1'b1;

   localparam logic [5:0] COLUMNS_RESET = 6'd20;
   localparam logic       BLINK_RESET   = 1'b1;

   // classified request handed from front to back
   typedef struct packed {
      logic [2:0] mode;
      logic       device_busy;
      logic       in_range;
      logic [7:0] byte_value;
      logic       phase_value;
   } op_type;

   // one result
   typedef struct packed {
      logic [1:0] out_kind;
      logic [1:0] cursor_row;
      logic [7:0] char_out;
   } rsp_type;

endpackage

`default_nettype wire

>>> sv/tdre_front.sv
`default_nettype none

module tdre_front #(
   parameter int COLS_W = 6,
   parameter int POS_W  = 8,
   parameter int ADDR_W = 8
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   output logic                  full,
   input  wire  [2:0]            req_mode,
   input  wire                   req_device_busy,
   input  wire  [1:0]            req_row,
   input  wire  [5:0]            req_col,
   input  wire  [7:0]            req_byte_value,
   input  wire                   req_phase_value,
   input  wire  [COLS_W-1:0]     cols,
   output logic                  op_valid,
   input  wire                   op_pop,
   output tdre_pkg::op_type      op,
   output logic [ADDR_W-1:0]     op_addr
);
   import tdre_pkg::*;

   logic [POS_W-1:0]  pos;
   logic [POS_W-1:0]  len;
   logic              push_acc;
   op_type            op_in;
   op_type            q_op_ff   [2];
   logic [ADDR_W-1:0] q_addr_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   // linear position and store length under the current column count
   assign pos = POS_W'(req_row) * POS_W'(cols) + POS_W'(req_col);
   assign len = POS_W'(ROWS) * POS_W'(cols);

   always_comb begin
      op_in.mode        = req_mode;
      op_in.device_busy = req_device_busy;
      op_in.in_range    = (pos < len);
      op_in.byte_value  = req_byte_value;
      op_in.phase_value = req_phase_value;
   end

   assign full     = (count_ff == 2'd2);
   assign push_acc = push && !full;
   assign op_valid = (count_ff != 2'd0);
   assign op       = q_op_ff[rd_ptr_ff];
   assign op_addr  = q_addr_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_acc;
      rd_ptr_in = rd_ptr_ff ^ op_pop;
      count_in  = count_ff + 2'(push_acc) - 2'(op_pop);
   end

   always_ff @(posedge clock) begin
      if (push_acc) begin
         q_op_ff[wr_ptr_ff]   <= op_in;
         q_addr_ff[wr_ptr_ff] <= pos[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/tdre_back.sv
`default_nettype none

module tdre_back #(
   parameter int COLS_W = 6,
   parameter int LEN_W  = 8,
   parameter int ADDR_W = 8,
   parameter int DEPTH  = 160
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire  [COLS_W-1:0]     cols,
   input  wire                   blink_enable,
   input  wire                   op_valid,
   output logic                  op_pop,
   input  tdre_pkg::op_type      op,
   input  wire  [ADDR_W-1:0]     op_addr,
   output logic                  empty,
   input  wire                   pop,
   output tdre_pkg::rsp_type     rsp
);
   import tdre_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic              state_ff, state_in;
   logic              rd_mark_ff, rd_mark_in;
   logic [ADDR_W-1:0] hold_addr_ff, hold_addr_in;
   logic [LEN_W-1:0]  wp_ff, wp_in;
   logic [LEN_W-1:0]  rpos_ff, rpos_in;
   logic [2:0]        phase_ff, phase_in;
   logic              bphase_ff, bphase_in;

   logic [7:0]        mem [DEPTH];
   logic              valid_ff [DEPTH];
   logic [7:0]        rdata_ff;
   logic              rvalid_ff;
   logic [ADDR_W-1:0] raddr;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic              clear_en;

   logic [LEN_W-1:0]  len;
   logic [LEN_W-1:0]  cols_l;
   logic [LEN_W-1:0]  rpos_nxt;
   logic [1:0]        cur_row;
   logic [7:0]        cur_char;
   logic [7:0]        shown;

   rsp_type           res_q_ff [2];
   logic              res_wr_ff, res_rd_ff;
   logic [1:0]        res_count_ff, res_count_in;
   logic              res_push, res_pop;
   rsp_type           res_in;

   assign cols_l   = LEN_W'(cols);
   assign len      = LEN_W'(ROWS) * cols_l;
   assign rpos_nxt = rpos_ff + LEN_W'(1);
   assign cur_row  = (phase_ff < PHASE_DATA) ? phase_ff[1:0] : 2'd0;
   assign cur_char = rvalid_ff ? rdata_ff : SPACE_CHAR;
   assign raddr    = (op.mode == MODE_MARK_BLINK) ? op_addr : rpos_ff[ADDR_W-1:0];

   // blink attribute on the way out
   always_comb begin
      shown = cur_char;
      if (blink_enable) begin
         if (bphase_ff && cur_char[7]) begin
            shown = SPACE_CHAR;
         end else begin
            shown = cur_char & CHAR_MASK;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      rd_mark_in   = rd_mark_ff;
      hold_addr_in = hold_addr_ff;
      wp_in        = wp_ff;
      rpos_in      = rpos_ff;
      phase_in     = phase_ff;
      bphase_in    = bphase_ff;
      op_pop       = 1'b0;
      res_push     = 1'b0;
      res_in       = '{out_kind: KIND_NONE, cursor_row: 2'd0, char_out: 8'd0};
      mem_we       = 1'b0;
      mem_waddr    = op_addr;
      mem_wdata    = op.byte_value;
      clear_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (op_valid && res_count_ff != 2'd2) begin
               op_pop = 1'b1;
               unique case (op.mode)
                  MODE_REFRESH: begin
                     if (op.device_busy) begin
                        res_push = 1'b1;
                     end else if (phase_ff != PHASE_DATA || rpos_ff >= len) begin
                        res_push          = 1'b1;
                        res_in.out_kind   = KIND_CURSOR;
                        res_in.cursor_row = cur_row;
                        rpos_in           = LEN_W'(cur_row) * cols_l;
                        phase_in          = PHASE_DATA;
                     end else begin
                        rd_mark_in = 1'b0;
                        state_in   = ST_READ;
                     end
                  end
                  MODE_PUT_AT: begin
                     res_push = 1'b1;
                     if (!op.in_range) begin
                        res_in.out_kind = KIND_REJECT;
                     end else begin
                        mem_we = 1'b1;
                        wp_in  = LEN_W'(op_addr) + LEN_W'(1);
                     end
                  end
                  MODE_PUT_NEXT: begin
                     res_push = 1'b1;
                     if (wp_ff >= len) begin
                        res_in.out_kind = KIND_REJECT;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = wp_ff[ADDR_W-1:0];
                        wp_in     = wp_ff + LEN_W'(1);
                     end
                  end
                  MODE_MARK_BLINK: begin
                     if (!op.in_range) begin
                        res_push        = 1'b1;
                        res_in.out_kind = KIND_REJECT;
                     end else begin
                        rd_mark_in   = 1'b1;
                        hold_addr_in = op_addr;
                        state_in     = ST_READ;
                     end
                  end
                  MODE_CLEAR: begin
                     res_push = 1'b1;
                     clear_en = 1'b1;
                  end
                  MODE_TOGGLE_PHASE: begin
                     res_push  = 1'b1;
                     bphase_in = ~bphase_ff;
                  end
                  MODE_SET_PHASE: begin
                     res_push  = 1'b1;
                     bphase_in = op.phase_value;
                  end
                  default: begin
                     res_push = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            res_push = 1'b1;
            state_in = ST_IDLE;
            if (rd_mark_ff) begin
               mem_we    = 1'b1;
               mem_waddr = hold_addr_ff;
               mem_wdata = cur_char | BLINK_MARK;
            end else begin
               res_in.out_kind = KIND_CHAR;
               res_in.char_out = shown;
               rpos_in         = rpos_nxt;
               // row boundaries at one, two and three times the column count
               if (rpos_nxt >= len) begin
                  phase_in = 3'd0;
               end else if (rpos_nxt == cols_l) begin
                  phase_in = 3'd1;
               end else if (rpos_nxt == (cols_l << 1)) begin
                  phase_in = 3'd2;
               end else if (rpos_nxt == (cols_l << 1) + cols_l) begin
                  phase_in = 3'd3;
               end
            end
         end
      endcase
   end

   // character store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[raddr];
   end

   // per-entry written marks: an unwritten or cleared entry reads as a space
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
         rvalid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < DEPTH; i++) begin
            if (clear_en && LEN_W'(i) < len) begin
               valid_ff[i] <= 1'b0;
            end
            if (mem_we && mem_waddr == ADDR_W'(i)) begin
               valid_ff[i] <= 1'b1;
            end
         end
         rvalid_ff <= valid_ff[raddr];
      end
   end

   always_ff @(posedge clock) begin
      hold_addr_ff <= hold_addr_in;
      rd_mark_ff   <= rd_mark_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         wp_ff     <= '0;
         rpos_ff   <= '0;
         phase_ff  <= 3'd0;
         bphase_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wp_ff     <= wp_in;
         rpos_ff   <= rpos_in;
         phase_ff  <= phase_in;
         bphase_ff <= bphase_in;
      end
   end

   // result queue
   assign empty        = (res_count_ff == 2'd0);
   assign res_pop      = pop && !empty;
   assign rsp          = res_q_ff[res_rd_ff];
   assign res_count_in = res_count_ff + 2'(res_push) - 2'(res_pop);

   always_ff @(posedge clock) begin
      if (res_push) begin
         res_q_ff[res_wr_ff] <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_wr_ff    <= 1'b0;
         res_rd_ff    <= 1'b0;
         res_count_ff <= 2'd0;
      end else begin
         res_wr_ff    <= res_wr_ff ^ res_push;
         res_rd_ff    <= res_rd_ff ^ res_pop;
         res_count_ff <= res_count_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/text_display_refresh_engine.sv
`default_nettype none

// channel     direction  handshake                  payload
// request     in         push / full                req_mode, req_device_busy, req_row,
//                                                   req_col, req_byte_value, req_phase_value
// response    out        pop / empty                rsp_out_kind, rsp_cursor_row, rsp_char_out
// csr         in/out     psel, penable, pwrite      paddr, pwdata, prdata (word 0 columns,
//                        pready                     word 1 blink attribute enable)
//
// a request enters a two-entry queue at its accepting edge; the back end takes it from
// there while the response queue has room; a data refresh tick or a blink mark passes
// through a read state, waiting for the registered read of the character store
// each store entry has a written mark; a clear drops those within the length at once
// reset empties both queues and makes the whole store read as spaces, no clearing pass
// full rises with two requests queued; the back end stalls on two queued responses

module text_display_refresh_engine #(
   parameter int MAX_COLS = 40
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         push,
   output logic        full,
   input  wire  [2:0]  req_mode,
   input  wire         req_device_busy,
   input  wire  [1:0]  req_row,
   input  wire  [5:0]  req_col,
   input  wire  [7:0]  req_byte_value,
   input  wire         req_phase_value,
   output logic        empty,
   input  wire         pop,
   output logic [1:0]  rsp_out_kind,
   output logic [1:0]  rsp_cursor_row,
   output logic [7:0]  rsp_char_out,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [2:0]  paddr,
   input  wire  [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import tdre_pkg::*;

   // store geometry follows from the column limit
   localparam int DEPTH  = ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LEN_W  = $clog2(DEPTH + 1);
   localparam int COLS_W = $clog2(MAX_COLS + 1);
   localparam int POS_W  = $clog2(ROWS * MAX_COLS + 64);

   logic [5:0]        columns_ff, columns_in;
   logic              blink_ff, blink_in;
   logic              csr_write;
   logic [COLS_W-1:0] cols;

   logic              op_valid;
   logic              op_pop;
   op_type            op;
   logic [ADDR_W-1:0] op_addr;
   rsp_type           rsp;

   // csr: always ready, word decode on paddr[2]
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      columns_in = columns_ff;
      blink_in   = blink_ff;
      if (csr_write) begin
         unique case (paddr[2])
            CSR_IDX_COLUMNS: columns_in = pwdata[5:0];
            CSR_IDX_BLINK:   blink_in   = pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_IDX_COLUMNS: prdata = {26'd0, columns_ff};
         CSR_IDX_BLINK:   prdata = {31'd0, blink_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= COLUMNS_RESET;
         blink_ff   <= BLINK_RESET;
      end else begin
         columns_ff <= columns_in;
         blink_ff   <= blink_in;
      end
   end

   // column count in use: zero acts as one, anything past the limit as the limit
   always_comb begin
      if (columns_ff == 6'd0) begin
         cols = COLS_W'(1);
      end else if ({1'b0, columns_ff} > 7'(MAX_COLS)) begin
         cols = COLS_W'(MAX_COLS);
      end else begin
         cols = COLS_W'(columns_ff);
      end
   end

   // front: takes requests, works out the linear position and range check
   tdre_front #(
      .COLS_W (COLS_W),
      .POS_W  (POS_W),
      .ADDR_W (ADDR_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_mode        (req_mode),
      .req_device_busy (req_device_busy),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_byte_value  (req_byte_value),
      .req_phase_value (req_phase_value),
      .cols            (cols),
      .op_valid        (op_valid),
      .op_pop          (op_pop),
      .op              (op),
      .op_addr         (op_addr)
   );

   // back: store, refresh walk, blink phase and the response queue
   tdre_back #(
      .COLS_W (COLS_W),
      .LEN_W  (LEN_W),
      .ADDR_W (ADDR_W),
      .DEPTH  (DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cols         (cols),
      .blink_enable (blink_ff),
      .op_valid     (op_valid),
      .op_pop       (op_pop),
      .op           (op),
      .op_addr      (op_addr),
      .empty        (empty),
      .pop          (pop),
      .rsp          (rsp)
   );

   assign rsp_out_kind   = rsp.out_kind;
   assign rsp_cursor_row = rsp.cursor_row;
   assign rsp_char_out   = rsp.char_out;

   // the back end only takes a request that the front has queued
   a_pop_needs_op: assert property (@(posedge clock) disable iff (reset)
      op_pop |-> op_valid)
      else $error("back end took a request from an empty queue");

   // after reset the response queue is empty and the request queue is not full
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (empty && !full))
      else $error("queues not empty after reset");

   // a columns write lands in the register
   a_columns_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && paddr[2] == CSR_IDX_COLUMNS) |=> (columns_ff == $past(pwdata[5:0])))
      else $error("columns register write lost");

   // only cursor responses carry a row, only character responses a byte
   a_rsp_fields: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((rsp_out_kind == KIND_CURSOR || rsp_cursor_row == 2'd0) &&
                  (rsp_out_kind == KIND_CHAR || rsp_char_out == 8'd0)))
      else $error("response carries a field its kind does not use");

endmodule

`default_nettype wire

>>> sim/tb_text_display_refresh_engine.sv
`default_nettype none

module tb_text_display_refresh_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import tdre_pkg::*;

   localparam int MAX_COLS     = 40;
   localparam int STORE_DEPTH  = ROWS * MAX_COLS;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 250;
   localparam int TAIL_CYCLES  = 16;
   localparam int IDLE_PERCENT = 35;

   // mode value the block leaves unused
   localparam logic [2:0] MODE_UNUSED = 3'd7;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request side
   logic        push            = 1'b0;
   logic        full;
   logic [2:0]  req_mode        = MODE_REFRESH;
   logic        req_device_busy = 1'b0;
   logic [1:0]  req_row         = 2'd0;
   logic [5:0]  req_col         = 6'd0;
   logic [7:0]  req_byte_value  = 8'd0;
   logic        req_phase_value = 1'b0;

   // response side
   logic        empty;
   logic        pop = 1'b0;
   logic [1:0]  rsp_out_kind;
   logic [1:0]  rsp_cursor_row;
   logic [7:0]  rsp_char_out;

   // csr side
   logic        psel    = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite  = 1'b0;
   logic [2:0]  paddr   = 3'd0;
   logic [31:0] pwdata  = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   // shadow of the display engine state
   logic [7:0]  shadow_chars [STORE_DEPTH];
   logic [2:0]  walk_phase;
   int unsigned walk_pos;
   int unsigned put_ptr;
   logic        blink_on;
   logic [5:0]  cols_reg;
   logic        blink_attr_reg;

   // display outputs still owed by the block, oldest first
   rsp_type     awaited_outputs [$];

   int          error_count = 0;
   int          cycle_count = 0;
   bit          idle_enable = 1'b1;
   int          hold_token  = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   text_display_refresh_engine #(
      .MAX_COLS (MAX_COLS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_mode        (req_mode),
      .req_device_busy (req_device_busy),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_byte_value  (req_byte_value),
      .req_phase_value (req_phase_value),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_cursor_row  (rsp_cursor_row),
      .rsp_char_out    (rsp_char_out),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // one line per mismatch, counted
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
      error_count++;
   endtask

   // column count as the block uses it: zero acts as one, clamp at the maximum
   function automatic int unsigned active_columns();
      if (cols_reg == 6'd0) return 1;
      if (cols_reg > MAX_COLS) return MAX_COLS;
      return cols_reg;
   endfunction

   // advance the shadow state by one request and return the display output it causes
   function automatic rsp_type next_display_output(input logic [2:0] mode,
                                                   input logic       busy,
                                                   input logic [1:0] row,
                                                   input logic [5:0] col,
                                                   input logic [7:0] byte_value,
                                                   input logic       phase_value);
      rsp_type     result;
      int unsigned cols;
      int unsigned len;
      int unsigned pos;
      int unsigned start_row;
      logic [7:0]  ch;
      cols   = active_columns();
      len    = ROWS * cols;
      pos    = row * cols + col;
      result = '{out_kind: KIND_NONE, cursor_row: 2'd0, char_out: 8'd0};
      case (mode)
         MODE_REFRESH: begin
            if (!busy) begin
               if (walk_phase != PHASE_DATA || walk_pos >= len) begin
                  // cursor to the start of a row; a stale position in the data phase restarts at row 0
                  start_row           = (walk_phase < PHASE_DATA) ? walk_phase : 0;
                  walk_pos            = start_row * cols;
                  walk_phase          = PHASE_DATA;
                  result.out_kind     = KIND_CURSOR;
                  result.cursor_row   = start_row[1:0];
               end else begin
                  ch = shadow_chars[walk_pos];
                  if (blink_attr_reg) begin
                     if (blink_on && ch[7]) ch = SPACE_CHAR;
                     else ch = ch & CHAR_MASK;
                  end
                  walk_pos++;
                  if (walk_pos >= len) walk_phase = 3'd0;
                  else if (walk_pos % cols == 0) walk_phase = 3'(walk_pos / cols);
                  result.out_kind = KIND_CHAR;
                  result.char_out = ch;
               end
            end
         end
         MODE_PUT_AT: begin
            if (pos >= len) result.out_kind = KIND_REJECT;
            else begin
               shadow_chars[pos] = byte_value;
               put_ptr = pos + 1;
            end
         end
         MODE_PUT_NEXT: begin
            if (put_ptr >= len) result.out_kind = KIND_REJECT;
            else begin
               shadow_chars[put_ptr] = byte_value;
               put_ptr++;
            end
         end
         MODE_MARK_BLINK: begin
            if (pos >= len) result.out_kind = KIND_REJECT;
            else shadow_chars[pos] = shadow_chars[pos] | BLINK_MARK;
         end
         MODE_CLEAR: begin
            for (int i = 0; i < len; i++) shadow_chars[i] = SPACE_CHAR;
         end
         MODE_TOGGLE_PHASE: blink_on = ~blink_on;
         MODE_SET_PHASE:    blink_on = phase_value;
         default: ;
      endcase
      return result;
   endfunction

   // offer one request until the block takes it; push stays high afterward
   task automatic send_request(input logic [2:0] mode,
                               input logic       busy,
                               input logic [1:0] row,
                               input logic [5:0] col,
                               input logic [7:0] byte_value,
                               input logic       phase_value);
      int gap;
      if (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
         push <= 1'b0;
         gap = $urandom_range(4, 1);
         repeat (gap) @(posedge clock);
      end
      push            <= 1'b1;
      req_mode        <= mode;
      req_device_busy <= busy;
      req_row         <= row;
      req_col         <= col;
      req_byte_value  <= byte_value;
      req_phase_value <= phase_value;
      @(posedge clock);
      while (full) @(posedge clock);
      // taken at this edge
      awaited_outputs.push_back(next_display_output(mode, busy, row, col,
                                                    byte_value, phase_value));
   endtask

   // random request: mostly refresh ticks and writes that land in the store
   task automatic send_random_request();
      int unsigned pick;
      int unsigned cols;
      logic [2:0]  mode;
      logic [5:0]  col;
      cols = active_columns();
      pick = $urandom_range(99);
      if (pick < 45)      mode = MODE_REFRESH;
      else if (pick < 60) mode = MODE_PUT_AT;
      else if (pick < 75) mode = MODE_PUT_NEXT;
      else if (pick < 83) mode = MODE_MARK_BLINK;
      else if (pick < 85) mode = MODE_CLEAR;
      else if (pick < 90) mode = MODE_TOGGLE_PHASE;
      else if (pick < 96) mode = MODE_SET_PHASE;
      else if (pick < 98) mode = MODE_UNUSED;
      else                mode = MODE_PUT_AT;
      if ($urandom_range(99) < 80) col = 6'($urandom_range(cols - 1, 0));
      else col = 6'($urandom_range(63, 0));
      send_request(mode, ($urandom_range(99) < 25), 2'($urandom_range(3, 0)), col,
                   8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
   endtask

   // stop offering and wait until every owed output has come back
   task automatic wait_for_outputs();
      push <= 1'b0;
      do @(posedge clock); while (awaited_outputs.size() != 0);
   endtask

   // csr write of one register, then read it back; only called with the block idle
   task automatic set_register(input logic idx, input logic [31:0] value);
      logic [31:0] want;
      want = (idx == CSR_IDX_COLUMNS) ? (value & 32'h3f) : (value & 32'h1);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (idx == CSR_IDX_COLUMNS) cols_reg = want[5:0];
      else blink_attr_reg = want[0];
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      // read back
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== want) report_mismatch("csr readback", prdata, want);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // response side: check each accepted response, then decide pop for the next cycle
   always @(posedge clock) begin : rsp_side
      rsp_type want;
      int      hold_seen;
      int      hold_left;
      if (reset) begin
         pop       <= 1'b0;
         hold_seen = hold_token;
         hold_left = 0;
      end else begin
         if (pop && !empty) begin
            if (awaited_outputs.size() == 0) begin
               report_mismatch("response with nothing owed, kind", rsp_out_kind, 0);
            end else begin
               want = awaited_outputs.pop_front();
               if (rsp_out_kind !== want.out_kind)
                  report_mismatch("out_kind", rsp_out_kind, want.out_kind);
               if (rsp_cursor_row !== want.cursor_row)
                  report_mismatch("cursor_row", rsp_cursor_row, want.cursor_row);
               if (rsp_char_out !== want.char_out)
                  report_mismatch("char_out", rsp_char_out, want.char_out);
            end
         end
         // a long hold-off was asked for
         if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** text_display_refresh_engine: FAILED **");
         $finish;
      end
   end

   // extremes of every field, every mode, rejects, blink handling and busy ticks
   task automatic test_directed_modes();
      send_request(MODE_REFRESH,      1'b1, 2'd3, 6'd63, 8'hff, 1'b1); // busy tick, nothing
      send_request(MODE_REFRESH,      1'b0, 2'd0, 6'd0,  8'h00, 1'b0); // cursor to row 0
      send_request(MODE_PUT_AT,       1'b1, 2'd3, 6'd19, 8'hff, 1'b0); // last entry, busy ignored
      send_request(MODE_PUT_NEXT,     1'b0, 2'd0, 6'd0,  8'h41, 1'b0); // pointer past the store
      send_request(MODE_PUT_AT,       1'b0, 2'd3, 6'd63, 8'h41, 1'b0); // beyond the store
      send_request(MODE_MARK_BLINK,   1'b0, 2'd3, 6'd63, 8'h00, 1'b0); // beyond the store
      send_request(MODE_PUT_AT,       1'b0, 2'd0, 6'd0,  8'h00, 1'b1);
      send_request(MODE_PUT_NEXT,     1'b0, 2'd0, 6'd0,  8'hc1, 1'b0);
      send_request(MODE_PUT_NEXT,     1'b0, 2'd0, 6'd0,  8'h7f, 1'b0);
      send_request(MODE_MARK_BLINK,   1'b1, 2'd0, 6'd2,  8'h00, 1'b0);
      send_request(MODE_REFRESH,      1'b0, 2'd0, 6'd0,  8'h00, 1'b0);
      send_request(MODE_SET_PHASE,    1'b0, 2'd0, 6'd0,  8'h00, 1'b1);
      send_request(MODE_REFRESH,      1'b0, 2'd0, 6'd0,  8'h00, 1'b0); // marked, sent as space
      send_request(MODE_TOGGLE_PHASE, 1'b1, 2'd0, 6'd0,  8'h00, 1'b0);
      send_request(MODE_REFRESH,      1'b0, 2'd0, 6'd0,  8'h00, 1'b0); // mark masked off
      send_request(MODE_UNUSED,       1'b1, 2'd3, 6'd63, 8'hff, 1'b1);
      send_request(MODE_CLEAR,        1'b1, 2'd0, 6'd0,  8'h00, 1'b0);
      send_request(MODE_REFRESH,      1'b0, 2'd0, 6'd0,  8'h00, 1'b0);
      send_request(MODE_SET_PHASE,    1'b0, 2'd0, 6'd0,  8'h00, 1'b0);
      send_request(MODE_PUT_AT,       1'b0, 2'd1, 6'd0,  8'h5a, 1'b0);
      send_request(MODE_PUT_NEXT,     1'b0, 2'd0, 6'd0,  8'ha5, 1'b0);
      wait_for_outputs();
   endtask

   // column counts at and past the limits, with and without the blink attribute
   task automatic test_column_limits();
      logic [5:0] col_set   [6] = '{6'd1, 6'd40, 6'd0, 6'd63, 6'd41, 6'd20};
      logic       blink_set [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
      for (int k = 0; k < 6; k++) begin
         set_register(CSR_IDX_COLUMNS, {26'd0, col_set[k]});
         set_register(CSR_IDX_BLINK, {31'd0, blink_set[k]});
         repeat (55) send_random_request();
         wait_for_outputs();
      end
   endtask

   // walk deep into a wide store, then shrink it so the position is stale
   task automatic test_shrink_during_walk();
      set_register(CSR_IDX_COLUMNS, 32'd40);
      set_register(CSR_IDX_BLINK, 32'd1);
      repeat (63) send_request(MODE_REFRESH, 1'b0, 2'd0, 6'd0, 8'h00, 1'b0);
      wait_for_outputs();
      set_register(CSR_IDX_COLUMNS, 32'd10);
      repeat (6) send_request(MODE_REFRESH, 1'b0, 2'd0, 6'd0, 8'h00, 1'b0);
      wait_for_outputs();
      set_register(CSR_IDX_COLUMNS, 32'd0);
      repeat (8) send_random_request();
      wait_for_outputs();
   endtask

   // random settings, random traffic
   task automatic test_random_traffic();
      logic [5:0] cols;
      for (int k = 0; k < 9; k++) begin
         if ($urandom_range(99) < 70) cols = 6'($urandom_range(MAX_COLS, 1));
         else cols = 6'($urandom_range(63, 0));
         set_register(CSR_IDX_COLUMNS, {26'd0, cols});
         set_register(CSR_IDX_BLINK, {31'd0, 1'($urandom_range(1, 0))});
         repeat (80) send_random_request();
         wait_for_outputs();
      end
   endtask

   // back-to-back traffic on both sides
   task automatic test_no_idle_stretch();
      idle_enable = 1'b0;
      repeat (160) send_random_request();
      wait_for_outputs();
      idle_enable = 1'b1;
   endtask

   // receiver holds off while requests keep coming, so full must stall the sender
   task automatic test_receiver_hold();
      hold_token++;
      repeat (60) send_random_request();
      wait_for_outputs();
   endtask

   initial begin
      // shadow state after reset
      for (int i = 0; i < STORE_DEPTH; i++) shadow_chars[i] = SPACE_CHAR;
      walk_phase     = 3'd0;
      walk_pos       = 0;
      put_ptr        = 0;
      blink_on       = 1'b0;
      cols_reg       = COLUMNS_RESET;
      blink_attr_reg = BLINK_RESET;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed_modes();
      test_column_limits();
      test_shrink_during_walk();
      test_random_traffic();
      test_no_idle_stretch();
      test_receiver_hold();

      // drained; give any stray response time to show up
      wait_for_outputs();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (!empty) report_mismatch("response left after drain, kind", rsp_out_kind, 0);

      if (error_count == 0) begin
         $display("** text_display_refresh_engine: PASSED **");
      end else begin
         $display("** text_display_refresh_engine: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
